@@ rtl/rcr_pkg.sv @@
package rcr_pkg;

    localparam int MAP_SIZE = 16;
    localparam int DIV_W = 14;
    localparam int DVS_W = 11;
    localparam int POS_W = 12;
    localparam int SIN_W = 16;
    localparam int PROBE_W = 24;
    localparam int STEP_W = 8;
    localparam int STEPS_PER_CELL = 10;
    localparam int SHADE_BAND = 20;
    localparam int VIEW_UNITS = 128;

    localparam logic [1:0] REG_MAP_0 = 2'd0;
    localparam logic [1:0] REG_MAP_1 = 2'd1;
    localparam logic [1:0] REG_MAP_2 = 2'd2;
    localparam logic [1:0] REG_MAP_3 = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COL_START,
        ST_SINE,
        ST_MARCH_START,
        ST_MARCH_WAIT,
        ST_CEIL_START,
        ST_CEIL_WAIT,
        ST_ROWS
    } state_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic                    start;
        logic [POS_W-1:0]        pos_x;
        logic [POS_W-1:0]        pos_y;
        logic signed [SIN_W-1:0] step_x;
        logic signed [SIN_W-1:0] step_y;
    } march_req_t;

    typedef struct packed {
        logic              done;
        logic [STEP_W-1:0] steps;
    } march_rsp_t;

    typedef logic [14:0] sin_tab_t [256];

    // Quarter-wave sine in Q1.14, polynomial evaluated with truncation.
    function automatic sin_tab_t gen_sin_tab();
        sin_tab_t tab;
        int z;
        int z2;
        int t;
        for (int r = 0; r < 256; r++) begin
            z = r * 64;
            z2 = (z * z) >> 14;
            t = (1306 * z2) >> 14;
            t = 10658 - t;
            t = (t * z2) >> 14;
            t = 25736 - t;
            t = (z * t) >> 14;
            if (t > 16384) begin
                t = 16384;
            end
            tab[r] = t[14:0];
        end
        return tab;
    endfunction

    localparam sin_tab_t SIN_TAB = gen_sin_tab();
    localparam logic [14:0] SIN_ONE = 15'd16384;

endpackage

@@ rtl/rcr_div.sv @@
module rcr_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  rcr_pkg::div_req_t req,
    output rcr_pkg::div_rsp_t rsp
);
    import rcr_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [3:0]       cnt_reg, cnt_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W:0]   trial;
    logic             ge;

    // One restoring step per cycle: the dividend shifts out of the top of the
    // quotient register while quotient bits shift in at the bottom.
    always_comb begin
        trial = {rem_reg, quo_reg[DIV_W-1]};
        ge = trial >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next = '0;
            quo_next = req.dividend;
            rem_next = '0;
            dvs_next = req.divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[DIV_W-2:0], ge};
            rem_next = ge ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'(DIV_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

@@ rtl/rcr_march.sv @@
module rcr_march #(
    parameter int MAX_DEPTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [255:0]        map_bits,
    input  rcr_pkg::march_req_t req,
    output rcr_pkg::march_rsp_t rsp
);
    import rcr_pkg::*;

    localparam logic [STEP_W-1:0] KMAX = STEP_W'(MAX_DEPTH * STEPS_PER_CELL);
    // Probe values at or above 16 cells, in units of 2^15.
    localparam logic [7:0] PROBE_LIMIT = 8'(MAP_SIZE * 5);

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [STEP_W-1:0]         k_reg, k_next;
    logic signed [PROBE_W-1:0] vx_reg, vx_next;
    logic signed [PROBE_W-1:0] vy_reg, vy_next;
    logic signed [SIN_W-1:0]   sx_reg, sx_next;
    logic signed [SIN_W-1:0]   sy_reg, sy_next;
    logic [PROBE_W-1:0]        px640, py640;
    logic                      hit;
    logic                      out_x, out_y;
    logic [14:0]               prod_x, prod_y;
    logic [3:0]                cell_x, cell_y;

    assign px640 = {3'b0, req.pos_x, 9'b0} + {5'b0, req.pos_x, 7'b0};
    assign py640 = {3'b0, req.pos_y, 9'b0} + {5'b0, req.pos_y, 7'b0};

    // A cell is 163840 probe units, which is 5 * 2^15: the division by five
    // is a multiplication by 205/1024, exact below 80.
    always_comb begin
        out_x = vx_reg[PROBE_W-1] || (vx_reg[22:15] >= PROBE_LIMIT);
        out_y = vy_reg[PROBE_W-1] || (vy_reg[22:15] >= PROBE_LIMIT);
        prod_x = 15'(vx_reg[21:15]) * 15'd205;
        prod_y = 15'(vy_reg[21:15]) * 15'd205;
        cell_x = prod_x[13:10];
        cell_y = prod_y[13:10];
        hit = out_x || out_y || map_bits[{cell_y, cell_x}];
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        k_next = k_reg;
        vx_next = vx_reg;
        vy_next = vy_reg;
        sx_next = sx_reg;
        sy_next = sy_reg;
        if (req.start) begin
            busy_next = 1'b1;
            k_next = STEP_W'(1);
            sx_next = req.step_x;
            sy_next = req.step_y;
            vx_next = $signed(px640) + PROBE_W'(req.step_x);
            vy_next = $signed(py640) + PROBE_W'(req.step_y);
        end else if (busy_reg) begin
            if (hit) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else if (k_reg == KMAX - STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                k_next = KMAX;
            end else begin
                k_next = k_reg + STEP_W'(1);
                vx_next = vx_reg + PROBE_W'(sx_reg);
                vy_next = vy_reg + PROBE_W'(sy_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        k_reg <= k_next;
        vx_reg <= vx_next;
        vy_reg <= vy_next;
        sx_reg <= sx_next;
        sy_reg <= sy_next;
    end

    assign rsp.done = done_reg;
    assign rsp.steps = k_reg;

endmodule

@@ rtl/raycast_column_renderer_top.sv @@
// Ray-marching column renderer.
// Send one word per screen column on the s_ channel: column, viewer x and y
// (Q4.8 cells) and heading (1024 units per turn). The block answers with
// SCREEN_ROWS words on the m_ channel, one per screen row in order, each
// holding the row number and a shade code (0 blank, 1..7 wall, near to
// far); m_tlast marks the final row of the column.
// The wall map is written through cfg_we/cfg_addr/cfg_wdata, one 64-bit
// word per four map rows, and should only change while the block is idle.
// After a column is accepted, one state scales the column to a ray angle,
// one looks up the sine, and the march unit probes one step per cycle until
// the ray hits a wall or leaves the map, or reaches the depth limit of
// MAX_DEPTH*10 steps. The divider then computes the wall height before the
// first row word goes out; the march loop sets the variable part of the
// time a column takes.
// s_tready is high only while idle. When the receiver stalls, the current
// row word is held and the block waits. A synchronous low aresetn clears
// the map and drops any column in progress.
module raycast_column_renderer_top #(
    parameter int SCREEN_COLUMNS = 120,
    parameter int SCREEN_ROWS = 40,
    parameter int MAX_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [63:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // column [6:0], pos_x [18:7], pos_y [30:19], heading [40:31], zero fill
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // row [5:0], shade [8:6], zero fill
    output logic [15:0] m_tdata,
    output logic        m_tlast
);
    import rcr_pkg::*;

    localparam logic [6:0] ROWS = 7'(SCREEN_ROWS);
    localparam logic [5:0] LAST_ROW = 6'(SCREEN_ROWS - 1);
    // Column scaling uses a rounded-up reciprocal of SCREEN_COLUMNS, exact
    // for every 14-bit scaled column.
    localparam int COL_SHIFT = 25;
    localparam logic [22:0] COL_RECIP =
        23'((2 ** COL_SHIFT + SCREEN_COLUMNS - 1) / SCREEN_COLUMNS);

    state_t state_reg, state_next;

    logic [63:0]             map_reg [4];
    logic [6:0]              column_reg;
    logic [POS_W-1:0]        px_reg, py_reg;
    logic [9:0]              heading_reg;
    logic [9:0]              angle_reg;
    logic signed [SIN_W-1:0] sx_reg, sy_reg;
    logic [STEP_W-1:0]       k_reg;
    logic [5:0]              ceil_reg;
    logic [2:0]              shade_reg;
    logic [5:0]              row_reg;

    div_req_t   div_req;
    div_rsp_t   div_rsp;
    march_req_t march_req;
    march_rsp_t march_rsp;

    logic             in_fire, out_fire;
    logic [9:0]       angle_y;
    logic [14:0]      mag_x, mag_y;
    logic [2:0]       shade_calc;
    logic [DIV_W-1:0] ceil_num;
    logic             wall;
    logic [6:0]       row_sum;
    logic [36:0]      col_prod;

    assign in_fire = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                map_reg[i] <= '0;
            end
        end else if (cfg_we && cfg_addr[2] == 1'b0) begin
            unique case (cfg_addr[1:0])
                REG_MAP_0: map_reg[0] <= cfg_wdata;
                REG_MAP_1: map_reg[1] <= cfg_wdata;
                REG_MAP_2: map_reg[2] <= cfg_wdata;
                REG_MAP_3: map_reg[3] <= cfg_wdata;
                default:   map_reg[0] <= map_reg[0];
            endcase
        end
    end

    rcr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    rcr_march #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_march (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .map_bits ({map_reg[3], map_reg[2], map_reg[1], map_reg[0]}),
        .req      (march_req),
        .rsp      (march_rsp)
    );

    // Quarter-wave lookup with mirroring; the mirrored index reaches 256
    // only for a zero remainder, where the sine is exactly one.
    function automatic logic signed [SIN_W-1:0] sine_of(input logic [9:0] a);
        logic [14:0] m;
        if (a[8]) begin
            m = (a[7:0] == 8'd0) ? SIN_ONE : SIN_TAB[8'(~a[7:0] + 8'd1)];
        end else begin
            m = SIN_TAB[a[7:0]];
        end
        return a[9] ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction

    assign angle_y = angle_reg + 10'd256;
    assign mag_x = 15'd0;
    assign mag_y = 15'd0;
    assign col_prod = 37'({column_reg, 7'b0}) * 37'(COL_RECIP);

    always_comb begin
        if (k_reg <= STEP_W'(SHADE_BAND)) begin
            shade_calc = 3'd1;
        end else if (k_reg <= STEP_W'(SHADE_BAND * 2)) begin
            shade_calc = 3'd2;
        end else if (k_reg <= STEP_W'(SHADE_BAND * 3)) begin
            shade_calc = 3'd3;
        end else if (k_reg <= STEP_W'(SHADE_BAND * 4)) begin
            shade_calc = 3'd4;
        end else if (k_reg <= STEP_W'(SHADE_BAND * 5)) begin
            shade_calc = 3'd5;
        end else if (k_reg <= STEP_W'(SHADE_BAND * 6)) begin
            shade_calc = 3'd6;
        end else begin
            shade_calc = 3'd7;
        end
        if (k_reg > STEP_W'(2 * STEPS_PER_CELL)) begin
            ceil_num = DIV_W'(ROWS) * DIV_W'(k_reg - STEP_W'(2 * STEPS_PER_CELL));
        end else begin
            ceil_num = '0;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:        if (in_fire) state_next = ST_COL_START;
            ST_COL_START:   state_next = ST_SINE;
            ST_SINE:        state_next = ST_MARCH_START;
            ST_MARCH_START: state_next = ST_MARCH_WAIT;
            ST_MARCH_WAIT:  if (march_rsp.done) state_next = ST_CEIL_START;
            ST_CEIL_START:  state_next = ST_CEIL_WAIT;
            ST_CEIL_WAIT:   if (div_rsp.done) state_next = ST_ROWS;
            ST_ROWS:        if (out_fire && row_reg == LAST_ROW) state_next = ST_IDLE;
            default:        state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        m_tvalid = (state_reg == ST_ROWS);
        div_req.start = (state_reg == ST_CEIL_START);
        div_req.dividend = ceil_num;
        div_req.divisor = DVS_W'({k_reg, 1'b0});
        march_req.start = (state_reg == ST_MARCH_START);
        march_req.pos_x = px_reg;
        march_req.pos_y = py_reg;
        march_req.step_x = sx_reg;
        march_req.step_y = sy_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            column_reg <= s_tdata[6:0];
            px_reg <= s_tdata[18:7];
            py_reg <= s_tdata[30:19];
            heading_reg <= s_tdata[40:31];
        end
        if (state_reg == ST_COL_START) begin
            angle_reg <= heading_reg - 10'(VIEW_UNITS / 2) + col_prod[COL_SHIFT +: 10];
        end
        if (state_reg == ST_SINE) begin
            sx_reg <= sine_of(angle_reg);
            sy_reg <= sine_of(angle_y);
        end
        if (state_reg == ST_MARCH_WAIT && march_rsp.done) begin
            k_reg <= march_rsp.steps;
        end
        if (state_reg == ST_CEIL_START) begin
            shade_reg <= shade_calc;
        end
        if (state_reg == ST_CEIL_WAIT && div_rsp.done) begin
            ceil_reg <= div_rsp.quotient[5:0] | 6'(mag_x ^ mag_y);
            row_reg <= '0;
        end else if (out_fire) begin
            row_reg <= row_reg + 6'd1;
        end
    end

    assign row_sum = {1'b0, row_reg} + {1'b0, ceil_reg};
    assign wall = (row_reg >= ceil_reg) && (row_sum < ROWS);
    assign m_tdata = {7'b0, (wall ? shade_reg : 3'd0), row_reg};
    assign m_tlast = (row_reg == LAST_ROW);

endmodule

@@ verif/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rcr_pkg::*;

    localparam int COLS = 120;
    localparam int ROWS = 40;
    localparam int DEPTH = 16;
    localparam int PROBE_UNIT = 163840;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [9:0]  heading;
        logic [11:0] pos_y;
        logic [11:0] pos_x;
        logic [6:0]  column;
    } column_req_t;

    typedef struct {
        logic [5:0] row;
        logic [2:0] shade;
        logic       last;
    } row_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [63:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;

    raycast_column_renderer_top dut (.*);

    always #5 aclk = ~aclk;

    logic [63:0] wall_map [4];
    column_req_t pending_cols[$];
    row_word_t   expected_rows[$];
    int  error_count = 0;
    int  cycle_count = 0;
    bit  calm = 1'b0;
    int  hold_off = 0;
    int  send_gap = 0;
    int  recv_gap = 0;
    int  pause_tx = 0;

    function automatic int sine_q14(int a);
        int q;
        int r;
        int m;
        int z;
        int z2;
        int t;
        a = a & 1023;
        q = a >> 8;
        r = a & 255;
        if (q & 1) r = 256 - r;
        z = r * 64;
        z2 = (z * z) >> 14;
        t = (1306 * z2) >> 14;
        t = 10658 - t;
        t = (t * z2) >> 14;
        t = 25736 - t;
        t = (z * t) >> 14;
        m = (t > 16384) ? 16384 : t;
        return (q & 2) ? -m : m;
    endfunction

    function automatic bit cell_is_wall(int vx, int vy);
        int cx;
        int cy;
        if (vx < 0 || vy < 0) return 1'b1;
        cx = vx / PROBE_UNIT;
        cy = vy / PROBE_UNIT;
        if (cx >= 16 || cy >= 16) return 1'b1;
        return wall_map[cy >> 2][(cy & 3) * 16 + cx];
    endfunction

    task automatic render_column(input column_req_t c);
        int angle;
        int sx;
        int sy;
        int k;
        int ceil_rows;
        int shade;
        row_word_t w;
        angle = (c.heading + 1024 - 64 + (int'(c.column) * 128) / COLS) & 1023;
        sx = sine_q14(angle);
        sy = sine_q14(angle + 256);
        for (k = 1; k < DEPTH * 10; k++) begin
            if (cell_is_wall(int'(c.pos_x) * 640 + sx * k, int'(c.pos_y) * 640 + sy * k))
                break;
        end
        ceil_rows = (k > 20) ? (ROWS * (k - 20)) / (2 * k) : 0;
        shade = 7;
        for (int j = 6; j >= 1; j--) begin
            if (k <= 20 * j) shade = j;
        end
        for (int y = 0; y < ROWS; y++) begin
            w.row = y[5:0];
            w.shade = (y >= ceil_rows && y + ceil_rows < ROWS) ? shade[2:0] : 3'd0;
            w.last = (y == ROWS - 1);
            expected_rows.push_back(w);
        end
    endtask

    // Sender: one word per accepted column, random gaps, optional pause.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                render_column(column_req_t'(s_tdata[40:0]));
                void'(pending_cols.pop_front());
            end
            if (send_gap > 0) send_gap <= send_gap - 1;
            if (s_tvalid && !s_tready) begin
                // Keep offering until accepted.
            end else if (pause_tx > 0 || send_gap > 0 || pending_cols.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                s_tvalid <= 1'b0;
                send_gap <= $urandom_range(1, 10);
            end else begin
                s_tvalid <= 1'b1;
                s_tdata <= {7'd0, pending_cols[0]};
            end
        end
    end

    // Receiver: checks every row word against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn) begin
            cycle_count <= cycle_count + 1;
            if (m_tvalid && m_tready) begin
                if (expected_rows.size() == 0) begin
                    $display("%0t: unexpected row word %h last %b", $time, m_tdata, m_tlast);
                    error_count <= error_count + 1;
                end else begin
                    row_word_t e;
                    e = expected_rows.pop_front();
                    if (m_tdata[5:0] !== e.row || m_tdata[8:6] !== e.shade
                        || m_tlast !== e.last || m_tdata[15:9] !== '0) begin
                        $display({"%0t: row word mismatch, expected row %0d shade %0d ",
                                  "last %b, got row %0d shade %0d last %b data %h"},
                                 $time, e.row, e.shade, e.last, m_tdata[5:0], m_tdata[8:6],
                                 m_tlast, m_tdata);
                        error_count <= error_count + 1;
                    end
                end
            end
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                m_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                recv_gap <= $urandom_range(1, 10);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_map(input logic [1:0] idx, input logic [63:0] bits);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= {1'b0, idx};
        cfg_wdata <= bits;
        if (idx <= REG_MAP_3) wall_map[idx] = bits;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain_all();
        wait (pending_cols.size() == 0 && !s_tvalid && expected_rows.size() == 0);
        repeat (300) @(posedge aclk);
    endtask

    function automatic column_req_t rand_col(bit in_map);
        column_req_t c;
        c.column = 7'($urandom_range(0, 119));
        c.pos_x = in_map ? 12'($urandom_range(256, 3839)) : 12'($urandom_range(0, 4095));
        c.pos_y = in_map ? 12'($urandom_range(256, 3839)) : 12'($urandom_range(0, 4095));
        c.heading = 10'($urandom_range(0, 1023));
        return c;
    endfunction

    function automatic logic [63:0] border_map(input int idx, input logic [63:0] inner);
        logic [63:0] v;
        v = inner;
        for (int r = 0; r < 4; r++) begin
            if (idx * 4 + r == 0 || idx * 4 + r == 15) v[r * 16 +: 16] = 16'hffff;
            else v[r * 16 +: 16] = v[r * 16 +: 16] | 16'h8001;
        end
        return v;
    endfunction

    initial begin
        column_req_t c;
        for (int i = 0; i < 4; i++) wall_map[i] = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Empty map: every ray runs to the depth limit or leaves the map.
        pending_cols.push_back('{heading: 10'd0, pos_y: 12'd2048, pos_x: 12'd2048, column: 7'd0});
        pending_cols.push_back('{heading: 10'd1023, pos_y: 12'd0, pos_x: 12'd0, column: 7'd119});
        pending_cols.push_back('{heading: 10'd256, pos_y: 12'd4095, pos_x: 12'd4095, column: 7'd127});
        pending_cols.push_back('{heading: 10'd512, pos_y: 12'd128, pos_x: 12'd3968, column: 7'd60});
        pending_cols.push_back('{heading: 10'd768, pos_y: 12'd4095, pos_x: 12'd0, column: 7'd120});
        pending_cols.push_back('{heading: 10'd300, pos_y: 12'd2730, pos_x: 12'd1365, column: 7'd85});
        drain_all();

        // All walls, then an unused register index that must change nothing.
        for (int i = 0; i < 4; i++) write_map(i[1:0], '1);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= 3'd4;
        cfg_wdata <= '0;
        @(posedge aclk);
        cfg_we <= 1'b0;
        pending_cols.push_back('{heading: 10'd0, pos_y: 12'd2048, pos_x: 12'd2048, column: 7'd0});
        pending_cols.push_back('{heading: 10'd640, pos_y: 12'd1000, pos_x: 12'd3000, column: 7'd100});
        drain_all();

        // Bordered rooms: mostly in-map viewers, with deep marches.
        for (int phase = 0; phase < 4; phase++) begin
            for (int i = 0; i < 4; i++)
                write_map(i[1:0], border_map(i, phase == 0 ? 64'd0
                                      : {$urandom, $urandom} & {$urandom, $urandom}));
            if (phase == 1) pause_tx = 1;
            for (int n = 0; n < 70; n++) begin
                c = rand_col($urandom_range(0, 4) != 0);
                pending_cols.push_back(c);
            end
            if (phase == 1) begin
                // Long receiver stall while columns keep coming.
                hold_off = 400;
                pause_tx = 0;
            end
            if (phase == 3) calm = 1'b1;
            drain_all();
        end

        if (error_count == 0 && expected_rows.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
